// File: src/paced_segment_relay_controller_assert.svh
// Assertion macros for the paced segment relay controller.
// Used by the top level only; needs a signal named clock and one named reset in scope.
`ifndef PACED_SEGMENT_RELAY_CONTROLLER_ASSERT_SVH
`define PACED_SEGMENT_RELAY_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSRC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("paced segment relay controller check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("paced segment relay controller check failed");

`endif

// File: src/psrc_pkg.sv
// Shared types, codes and widths of the paced segment relay controller.
// Depends on nothing; used by every module of the block.
package psrc_pkg;

   localparam int SEQ_BITS  = 32;
   localparam int TIME_BITS = 40;
   localparam int BACK_BITS = 26;   // delay_seconds * 1000 fits here
   localparam int SEG_BITS  = 16;
   localparam int PROD_BITS = SEQ_BITS + SEG_BITS;

   // Relay states.
   localparam logic [3:0] M_IDLE   = 4'd0;
   localparam logic [3:0] M_WAIT   = 4'd1;
   localparam logic [3:0] M_AWAIT  = 4'd2;
   localparam logic [3:0] M_STREAM = 4'd3;
   localparam logic [3:0] M_STALL  = 4'd4;
   localparam logic [3:0] M_RECON  = 4'd5;
   localparam logic [3:0] M_END    = 4'd6;
   localparam logic [3:0] M_STOP   = 4'd7;
   localparam logic [3:0] M_BLOCK  = 4'd8;

   // Request kinds.
   localparam logic [1:0] K_POLL  = 2'd0;
   localparam logic [1:0] K_EXIT  = 2'd1;
   localparam logic [1:0] K_RECFG = 2'd2;

   // Actions.
   localparam logic [2:0] A_NONE  = 3'd0;
   localparam logic [2:0] A_KILL  = 3'd1;
   localparam logic [2:0] A_CLOSE = 3'd2;
   localparam logic [2:0] A_SPAWN = 3'd3;
   localparam logic [2:0] A_FEED  = 3'd4;

   // Room status codes.
   localparam logic [1:0] R_NONE  = 2'd0;
   localparam logic [1:0] R_ENDED = 2'd2;
   localparam logic [1:0] R_INTR  = 2'd3;

   // Event codes.
   localparam logic [4:0] E_NONE       = 5'd0;
   localparam logic [4:0] E_OP_KILL    = 5'd1;
   localparam logic [4:0] E_STOPPED    = 5'd2;
   localparam logic [4:0] E_BLOCKED    = 5'd3;
   localparam logic [4:0] E_UNBLOCKED  = 5'd4;
   localparam logic [4:0] E_LOST       = 5'd5;
   localparam logic [4:0] E_ROOM_GONE  = 5'd6;
   localparam logic [4:0] E_WAIT_START = 5'd7;
   localparam logic [4:0] E_ALL_SENT   = 5'd8;
   localparam logic [4:0] E_WAIT_DL    = 5'd9;
   localparam logic [4:0] E_RESPAWN    = 5'd10;
   localparam logic [4:0] E_SPAWN      = 5'd11;
   localparam logic [4:0] E_OUT_POINT  = 5'd12;
   localparam logic [4:0] E_INTR       = 5'd13;
   localparam logic [4:0] E_ENDED      = 5'd14;
   localparam logic [4:0] E_AWAIT      = 5'd15;
   localparam logic [4:0] E_BP_DROP    = 5'd16;
   localparam logic [4:0] E_CONNECTED  = 5'd17;
   localparam logic [4:0] E_FLOWING    = 5'd18;
   localparam logic [4:0] E_STALLED    = 5'd19;
   localparam logic [4:0] E_STARVE     = 5'd20;

   // Register indexes.
   localparam logic [2:0] REG_SEGMENT_MS = 3'd0;
   localparam logic [2:0] REG_DELAY      = 3'd1;
   localparam logic [2:0] REG_GRACE      = 3'd2;
   localparam logic [2:0] REG_REPLAY     = 3'd3;
   localparam logic [2:0] REG_IN_POINT   = 3'd4;
   localparam logic [2:0] REG_OUT_POINT  = 3'd5;
   localparam logic [2:0] REG_LISTENER   = 3'd6;

   typedef struct packed {
      logic [15:0]         segment_ms;
      logic [15:0]         delay_seconds;
      logic [15:0]         grace_seconds;
      logic                replay_from_start;
      logic [SEQ_BITS-1:0] in_point_seq;
      logic [SEQ_BITS-1:0] out_point_seq;
      logic                listener_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [TIME_BITS-1:0] now_ms;
      logic                 run_wanted;
      logic                 sender_alive;
      logic                 feed_ok;
      logic [1:0]           room_status;
      logic [SEQ_BITS-1:0]  oldest_seq;
      logic [SEQ_BITS-1:0]  newest_seq;
      logic                 init_present;
      logic                 next_present;
      logic                 sink_accepting;
      logic                 sink_ever_accepted;
   } req_type;

   typedef struct packed {
      logic [2:0]          action;
      logic [SEQ_BITS-1:0] fed_seq;
      logic [3:0]          relay_state;
      logic [4:0]          event_code;
      logic [SEQ_BITS-1:0] segments_behind;
      logic                behind_valid;
      logic [15:0]         restart_count;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic div_start;
      logic mul_en;
      logic eval_en;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic div_done;
      logic rsp_busy;
   } status_type;

endpackage

// File: src/paced_segment_relay_controller.sv
// Paced segment relay controller, top level: ports, register file, controller and datapath.
// A request is taken only while the controller is idle; it then runs the iterative divider
// for the delay-behind-live quotient (one divider bit per cycle), a multiply step and a commit
// step, which waits while the previous result is still held. The next request is taken while
// a result waits.
// Synchronous active-high reset returns registers to their defaults and the relay to idle.
module paced_segment_relay_controller (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata from bit 0: now_ms[39:0], run_wanted, sender_alive, feed_ok, room_status[1:0],
   // oldest_seq[31:0], newest_seq[31:0], init_present, next_present, sink_accepting,
   // sink_ever_accepted, zero fill.
   input  logic [119:0] req_tdata,
   // tuser: kind[1:0].
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata from bit 0: action[2:0], fed_seq[31:0], relay_state[3:0], event_code[4:0],
   // segments_behind[31:0], behind_valid, restart_count[15:0], zero fill.
   output logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [4:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   psrc_pkg::cfg_type    cfg_ff, cfg_in;
   psrc_pkg::req_type    req;
   psrc_pkg::rsp_type    rsp;
   psrc_pkg::cmd_type    cmd;
   psrc_pkg::status_type status;
   logic [2:0]           reg_idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            psrc_pkg::REG_SEGMENT_MS: cfg_in.segment_ms        = csr_pwdata[15:0];
            psrc_pkg::REG_DELAY:      cfg_in.delay_seconds     = csr_pwdata[15:0];
            psrc_pkg::REG_GRACE:      cfg_in.grace_seconds     = csr_pwdata[15:0];
            psrc_pkg::REG_REPLAY:     cfg_in.replay_from_start = csr_pwdata[0];
            psrc_pkg::REG_IN_POINT:   cfg_in.in_point_seq      = csr_pwdata;
            psrc_pkg::REG_OUT_POINT:  cfg_in.out_point_seq     = csr_pwdata;
            psrc_pkg::REG_LISTENER:   cfg_in.listener_mode     = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // Register read mux.
   always_comb begin
      unique case (reg_idx)
         psrc_pkg::REG_SEGMENT_MS: csr_prdata = {16'd0, cfg_ff.segment_ms};
         psrc_pkg::REG_DELAY:      csr_prdata = {16'd0, cfg_ff.delay_seconds};
         psrc_pkg::REG_GRACE:      csr_prdata = {16'd0, cfg_ff.grace_seconds};
         psrc_pkg::REG_REPLAY:     csr_prdata = {31'd0, cfg_ff.replay_from_start};
         psrc_pkg::REG_IN_POINT:   csr_prdata = cfg_ff.in_point_seq;
         psrc_pkg::REG_OUT_POINT:  csr_prdata = cfg_ff.out_point_seq;
         psrc_pkg::REG_LISTENER:   csr_prdata = {31'd0, cfg_ff.listener_mode};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.segment_ms        <= 16'd6000;
         cfg_ff.delay_seconds     <= 16'd0;
         cfg_ff.grace_seconds     <= 16'd30;
         cfg_ff.replay_from_start <= 1'b0;
         cfg_ff.in_point_seq      <= '0;
         cfg_ff.out_point_seq     <= '0;
         cfg_ff.listener_mode     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request.
   assign req.kind               = req_tuser;
   assign req.now_ms             = req_tdata[39:0];
   assign req.run_wanted         = req_tdata[40];
   assign req.sender_alive       = req_tdata[41];
   assign req.feed_ok            = req_tdata[42];
   assign req.room_status        = req_tdata[44:43];
   assign req.oldest_seq         = req_tdata[76:45];
   assign req.newest_seq         = req_tdata[108:77];
   assign req.init_present       = req_tdata[109];
   assign req.next_present       = req_tdata[110];
   assign req.sink_accepting     = req_tdata[111];
   assign req.sink_ever_accepted = req_tdata[112];

   psrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   psrc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .cmd        (cmd),
      .status     (status),
      .rsp        (rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   // Pack the result.
   assign rsp_tdata = {3'd0, rsp.restart_count, rsp.behind_valid, rsp.segments_behind,
                       rsp.event_code, rsp.relay_state, rsp.fed_seq, rsp.action};

`include "paced_segment_relay_controller_assert.svh"

   // Only one request is in work at a time.
   `PSRC_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready)
   // A fed segment number appears only with a feed action.
   `PSRC_ASSERT_SAME(a_fed_only_on_feed, rsp_tvalid && rsp.action != psrc_pkg::A_FEED,
                     rsp.fed_seq == '0)
   // The lag is reported only when it is valid.
   `PSRC_ASSERT_SAME(a_behind_gated, rsp_tvalid && !rsp.behind_valid,
                     rsp.segments_behind == '0)
   // The restart count never goes down.
   `PSRC_ASSERT_NEXT(a_restarts_monotonic, rsp_tvalid,
                     !rsp_tvalid || rsp.restart_count >= $past(rsp.restart_count))

endmodule

// File: src/psrc_div.sv
// Iterative restoring divider: one quotient bit per cycle.
// Depends on psrc_pkg for the operand widths.
module psrc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [psrc_pkg::BACK_BITS-1:0]      dividend,
   input  logic [psrc_pkg::SEG_BITS-1:0]       divisor,
   output logic [psrc_pkg::BACK_BITS-1:0]      quotient,
   output logic                                done
);

   localparam int CNT_BITS = $clog2(psrc_pkg::BACK_BITS + 1);

   logic [psrc_pkg::BACK_BITS-1:0] q_ff, q_in;
   logic [psrc_pkg::SEG_BITS:0]    rem_ff, rem_in;
   logic [CNT_BITS-1:0]            cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [psrc_pkg::SEG_BITS:0]    rem_shift;

   // One shift-and-subtract step per cycle while busy.
   always_comb begin
      q_in      = q_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = done_ff;
      rem_shift = {rem_ff[psrc_pkg::SEG_BITS-1:0], q_ff[psrc_pkg::BACK_BITS-1]};
      if (start) begin
         q_in    = dividend;
         rem_in  = '0;
         cnt_in  = CNT_BITS'(psrc_pkg::BACK_BITS);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, divisor}) begin
            rem_in = rem_shift - {1'b0, divisor};
            q_in   = {q_ff[psrc_pkg::BACK_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            q_in   = {q_ff[psrc_pkg::BACK_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
   end

   assign quotient = q_ff;
   assign done     = done_ff;

endmodule

// File: src/psrc_ctrl.sv
// Sequencing controller: accepts a request, runs the divide and multiply steps,
// then commits the step. Depends on psrc_pkg for the command and status structs.
module psrc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  psrc_pkg::status_type   status,
   output psrc_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_EVAL  = 3'd4;

   logic [2:0] state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) state_in = S_START;
         end
         S_START: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (status.div_done) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            // Hold the step until the result register is free.
            if (!status.rsp_busy) begin
               cmd.eval_en = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// File: src/psrc_datapath.sv
// Datapath: request latch, divider, pacing product, relay state and result register.
// Depends on psrc_pkg and psrc_div; driven by commands from psrc_ctrl.
module psrc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  psrc_pkg::cfg_type     cfg,
   input  psrc_pkg::req_type     req,
   input  psrc_pkg::cmd_type     cmd,
   output psrc_pkg::status_type  status,
   output psrc_pkg::rsp_type     rsp,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   localparam int TB = psrc_pkg::TIME_BITS;
   localparam int SB = psrc_pkg::SEQ_BITS;
   localparam logic [TB-1:0] TIME_MAX = '1;

   psrc_pkg::req_type r_ff;

   // Relay state.
   logic [3:0]    mode_ff, mode_in;
   logic [SB-1:0] head_ff, head_in;
   logic          hv_ff, hv_in;
   logic [TB-1:0] at_ff, at_in;
   logic [SB-1:0] as_ff, as_in;
   logic [TB-1:0] retry_ff, retry_in;
   logic [13:0]   backoff_ff, backoff_in;
   logic [TB-1:0] ss_ff, ss_in;
   logic          sok_ff, sok_in;
   logic [TB-1:0] od_ff, od_in;
   logic          odok_ff, odok_in;
   logic [TB-1:0] bu_ff, bu_in;
   logic          buok_ff, buok_in;
   logic [15:0]   rst_ff, rst_in;

   psrc_pkg::rsp_type rsp_ff, rsp_in;
   logic              rv_ff;

   logic [psrc_pkg::SEG_BITS-1:0]  seg_eff;
   logic [psrc_pkg::BACK_BITS-1:0] back_q;
   logic [psrc_pkg::PROD_BITS-1:0] prod_ff;
   logic [SB-1:0]                  dseq;

   // Effective segment duration.
   assign seg_eff = (cfg.segment_ms > 16'd100) ? cfg.segment_ms : 16'd6000;

   psrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (psrc_pkg::BACK_BITS'(cfg.delay_seconds * 26'd1000)),
      .divisor  (seg_eff),
      .quotient (back_q),
      .done     (status.div_done)
   );

   // Distance between head and anchor, in segments; the multiply step scales it to milliseconds.
   assign dseq = (head_ff >= as_ff) ? head_ff - as_ff : as_ff - head_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req;
      if (cmd.mul_en) prod_ff <= dseq * seg_eff;
   end

   // One relay step.
   always_comb begin
      logic                  done;
      logic                  fresh;
      logic                  nd;
      logic [SB-1:0]         want;
      logic [SB-1:0]         back_s;
      logic [25:0]           grace_ms;
      logic [TB:0]           sum;
      logic [14:0]           dbl;
      logic [TB-1:0]         now;
      logic [TB-1:0]         sat1000;
      logic                  reach_bu_g;
      logic                  reach_od_3;
      logic                  reach_od_g;
      logic [2:0]            act;
      logic [SB-1:0]         fed;
      logic [4:0]            ev;
      logic                  bvalid;

      mode_in    = mode_ff;
      head_in    = head_ff;
      hv_in      = hv_ff;
      at_in      = at_ff;
      as_in      = as_ff;
      retry_in   = retry_ff;
      backoff_in = backoff_ff;
      ss_in      = ss_ff;
      sok_in     = sok_ff;
      od_in      = od_ff;
      odok_in    = odok_ff;
      bu_in      = bu_ff;
      buok_in    = buok_ff;
      rst_in     = rst_ff;
      act        = psrc_pkg::A_NONE;
      fed        = '0;
      ev         = psrc_pkg::E_NONE;
      done       = 1'b0;
      fresh      = 1'b0;
      nd         = 1'b0;
      now        = r_ff.now_ms;
      grace_ms   = 26'(cfg.grace_seconds * 26'd1000);
      sat1000    = '0;
      sum        = '0;
      dbl        = '0;
      reach_bu_g = 1'b0;
      reach_od_3 = 1'b0;
      reach_od_g = 1'b0;

      // Position behind live, clamped to the storage window.
      back_s = SB'(back_q);
      want   = (r_ff.newest_seq > back_s) ? r_ff.newest_seq - back_s : '0;
      if (want < r_ff.oldest_seq) want = r_ff.oldest_seq;
      if (want > r_ff.newest_seq) want = r_ff.newest_seq;

      sum     = {1'b0, now} + (TB+1)'(1000);
      sat1000 = sum[TB] ? TIME_MAX : sum[TB-1:0];

      case (r_ff.kind)
         psrc_pkg::K_POLL: begin
            if (!r_ff.run_wanted) begin
               if (r_ff.sender_alive) begin
                  act = psrc_pkg::A_KILL; ev = psrc_pkg::E_OP_KILL;
                  mode_in = psrc_pkg::M_IDLE; buok_in = 1'b0; hv_in = 1'b0;
               end else if (mode_in != psrc_pkg::M_IDLE) begin
                  mode_in = psrc_pkg::M_IDLE; buok_in = 1'b0; hv_in = 1'b0;
                  ev = psrc_pkg::E_STOPPED;
               end
               done = 1'b1;
            end
            if (!done && !r_ff.feed_ok) begin
               if (r_ff.sender_alive) begin
                  act = psrc_pkg::A_KILL; ev = psrc_pkg::E_BLOCKED;
                  mode_in = psrc_pkg::M_BLOCK; buok_in = 1'b0;
               end else if (mode_in != psrc_pkg::M_BLOCK) begin
                  mode_in = psrc_pkg::M_BLOCK; buok_in = 1'b0;
                  ev = psrc_pkg::E_BLOCKED;
               end
               done = 1'b1;
            end
            if (!done && mode_in == psrc_pkg::M_BLOCK) begin
               mode_in = psrc_pkg::M_WAIT; buok_in = 1'b0; ev = psrc_pkg::E_UNBLOCKED;
            end
            if (!done && !r_ff.sender_alive && (mode_in == psrc_pkg::M_STREAM ||
                  mode_in == psrc_pkg::M_STALL || mode_in == psrc_pkg::M_AWAIT)) begin
               mode_in = psrc_pkg::M_RECON; buok_in = 1'b0; ev = psrc_pkg::E_LOST;
               done = 1'b1;
            end
            if (!done && r_ff.room_status == psrc_pkg::R_NONE) begin
               if (r_ff.sender_alive) begin
                  act = psrc_pkg::A_CLOSE; mode_in = psrc_pkg::M_END; buok_in = 1'b0;
                  ev = psrc_pkg::E_ROOM_GONE;
               end else if (mode_in != psrc_pkg::M_WAIT && mode_in != psrc_pkg::M_STOP) begin
                  mode_in = psrc_pkg::M_WAIT; buok_in = 1'b0; ev = psrc_pkg::E_WAIT_START;
               end
               done = 1'b1;
            end
            // Sender down: pick the head; spawn after the retry time once content is ready.
            if (!done && !r_ff.sender_alive) begin
               done = 1'b1;
               if (mode_in == psrc_pkg::M_END) begin
                  mode_in = psrc_pkg::M_STOP; buok_in = 1'b0; ev = psrc_pkg::E_ALL_SENT;
               end else if (mode_in != psrc_pkg::M_STOP) begin
                  if (!hv_in) begin
                     if (cfg.replay_from_start) begin
                        head_in = (cfg.in_point_seq > r_ff.oldest_seq) ?
                                  cfg.in_point_seq : r_ff.oldest_seq;
                     end else begin
                        head_in = want;
                     end
                     hv_in = 1'b1;
                  end else if (head_in < r_ff.oldest_seq) begin
                     head_in = r_ff.oldest_seq;
                  end
                  if (now >= retry_ff) begin
                     if (!r_ff.init_present || !r_ff.next_present) begin
                        if (mode_in != psrc_pkg::M_WAIT) begin
                           mode_in = psrc_pkg::M_WAIT; buok_in = 1'b0;
                           ev = psrc_pkg::E_WAIT_DL;
                        end
                     end else begin
                        at_in = now; as_in = head_in;
                        act = psrc_pkg::A_SPAWN;
                        ev = (mode_in == psrc_pkg::M_RECON) ? psrc_pkg::E_RESPAWN :
                                                              psrc_pkg::E_SPAWN;
                        mode_in = psrc_pkg::M_STREAM; ss_in = now; sok_in = 1'b1;
                        buok_in = 1'b0;
                     end
                  end
               end
            end
            // Sender up: end-of-content checks.
            if (!done && cfg.out_point_seq != '0 && head_in > cfg.out_point_seq &&
                  mode_in != psrc_pkg::M_END) begin
               act = psrc_pkg::A_CLOSE; mode_in = psrc_pkg::M_END; buok_in = 1'b0;
               ev = psrc_pkg::E_OUT_POINT; done = 1'b1;
            end
            if (!done && head_in > r_ff.newest_seq && (r_ff.room_status == psrc_pkg::R_ENDED ||
                  r_ff.room_status == psrc_pkg::R_INTR)) begin
               if (mode_in != psrc_pkg::M_END) begin
                  act = psrc_pkg::A_CLOSE; mode_in = psrc_pkg::M_END; buok_in = 1'b0;
                  ev = (r_ff.room_status == psrc_pkg::R_INTR) ? psrc_pkg::E_INTR :
                                                               psrc_pkg::E_ENDED;
               end
               done = 1'b1;
            end
            if (!done && mode_in == psrc_pkg::M_END) done = 1'b1;
            // Destination not taking content.
            if (!done && !r_ff.sink_accepting) begin
               done = 1'b1;
               if (cfg.listener_mode && !r_ff.sink_ever_accepted) begin
                  if (mode_in != psrc_pkg::M_AWAIT) begin
                     mode_in = psrc_pkg::M_AWAIT; ev = psrc_pkg::E_AWAIT;
                  end
                  if (!cfg.replay_from_start) head_in = want;
               end else begin
                  if (!buok_in) begin
                     bu_in = now; buok_in = 1'b1;
                  end
                  reach_bu_g = (now >= bu_in) && ((now - bu_in) >= TB'(grace_ms));
                  if (reach_bu_g) begin
                     act = psrc_pkg::A_KILL; ev = psrc_pkg::E_BP_DROP;
                     mode_in = psrc_pkg::M_RECON; buok_in = 1'b0;
                     retry_in = sat1000;
                  end
               end
            end
            // Destination taking content: pace the feed.
            if (!done) begin
               if (mode_in == psrc_pkg::M_AWAIT) begin
                  at_in = now; as_in = head_in; odok_in = 1'b0;
                  mode_in = psrc_pkg::M_STREAM; ss_in = now; sok_in = 1'b1;
                  ev = psrc_pkg::E_CONNECTED; fresh = 1'b1;
               end
               buok_in = 1'b0;
               if (fresh) begin
                  nd = 1'b0;
               end else if (head_ff >= as_ff) begin
                  nd = (now < at_ff) ||
                       ({{(psrc_pkg::PROD_BITS-TB){1'b0}}, now - at_ff} < prod_ff);
               end else if (prod_ff > {{(psrc_pkg::PROD_BITS-TB){1'b0}}, at_ff}) begin
                  nd = 1'b0;
               end else begin
                  nd = now < (at_ff - prod_ff[TB-1:0]);
               end
               if (nd) begin
                  odok_in = 1'b0;
                  if (mode_in == psrc_pkg::M_STALL) begin
                     mode_in = psrc_pkg::M_STREAM; ss_in = now; sok_in = 1'b1;
                     ev = psrc_pkg::E_FLOWING;
                  end
               end else if (!r_ff.next_present) begin
                  if (!odok_in) begin
                     od_in = now; odok_in = 1'b1;
                  end
                  reach_od_3 = (now >= od_in) && ((now - od_in) >= TB'(3000));
                  reach_od_g = (now >= od_in) && ((now - od_in) >= TB'(grace_ms));
                  if (reach_od_3 && mode_in != psrc_pkg::M_STALL) begin
                     mode_in = psrc_pkg::M_STALL; ev = psrc_pkg::E_STALLED;
                  end else if (reach_od_g) begin
                     act = psrc_pkg::A_KILL; ev = psrc_pkg::E_STARVE;
                     mode_in = psrc_pkg::M_RECON;
                     retry_in = sat1000; odok_in = 1'b0;
                  end
               end else begin
                  odok_in = 1'b0;
                  if (mode_in == psrc_pkg::M_STALL) begin
                     mode_in = psrc_pkg::M_STREAM; ss_in = now; sok_in = 1'b1;
                     ev = psrc_pkg::E_FLOWING;
                  end
                  act = psrc_pkg::A_FEED; fed = head_in;
                  head_in = head_in + 1'b1;
               end
            end
         end
         psrc_pkg::K_EXIT: begin
            if (rst_ff != 16'hFFFF) rst_in = rst_ff + 1'b1;
            backoff_in = backoff_ff;
            if (sok_ff && now > ss_ff && (now - ss_ff) > TB'(120000)) backoff_in = '0;
            if (backoff_in != '0) begin
               dbl = {backoff_in, 1'b0};
               backoff_in = (dbl > 15'd15000) ? 14'd15000 : dbl[13:0];
            end else begin
               backoff_in = 14'd1000;
            end
            sum      = {1'b0, now} + (TB+1)'(backoff_in);
            retry_in = sum[TB] ? TIME_MAX : sum[TB-1:0];
         end
         psrc_pkg::K_RECFG: begin
            mode_in = psrc_pkg::M_WAIT; hv_in = 1'b0; retry_in = '0;
            odok_in = 1'b0; buok_in = 1'b0;
            ss_in = now; sok_in = 1'b1;
         end
         default: ;
      endcase

      bvalid = hv_in && (mode_in == psrc_pkg::M_STREAM || mode_in == psrc_pkg::M_STALL ||
                         mode_in == psrc_pkg::M_END);
      rsp_in.action          = act;
      rsp_in.fed_seq         = fed;
      rsp_in.relay_state     = mode_in;
      rsp_in.event_code      = ev;
      rsp_in.segments_behind = (bvalid && r_ff.newest_seq >= head_in) ?
                               r_ff.newest_seq - head_in : '0;
      rsp_in.behind_valid    = bvalid;
      rsp_in.restart_count   = rst_in;
   end

   // State commit and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= psrc_pkg::M_IDLE;
         head_ff    <= '0;
         hv_ff      <= 1'b0;
         at_ff      <= '0;
         as_ff      <= '0;
         retry_ff   <= '0;
         backoff_ff <= '0;
         ss_ff      <= '0;
         sok_ff     <= 1'b0;
         od_ff      <= '0;
         odok_ff    <= 1'b0;
         bu_ff      <= '0;
         buok_ff    <= 1'b0;
         rst_ff     <= '0;
         rv_ff      <= 1'b0;
      end else begin
         if (cmd.eval_en) begin
            mode_ff    <= mode_in;
            head_ff    <= head_in;
            hv_ff      <= hv_in;
            at_ff      <= at_in;
            as_ff      <= as_in;
            retry_ff   <= retry_in;
            backoff_ff <= backoff_in;
            ss_ff      <= ss_in;
            sok_ff     <= sok_in;
            od_ff      <= od_in;
            odok_ff    <= odok_in;
            bu_ff      <= bu_in;
            buok_ff    <= buok_in;
            rst_ff     <= rst_in;
            rv_ff      <= 1'b1;
         end else if (rsp_tready) begin
            rv_ff <= 1'b0;
         end
      end
      if (cmd.eval_en) rsp_ff <= rsp_in;
   end

   assign rsp             = rsp_ff;
   assign rsp_tvalid      = rv_ff;
   assign status.rsp_busy = rv_ff && !rsp_tready;

endmodule

// File: tb/paced_segment_relay_controller_test.sv
// Self-checking testbench for the paced segment relay controller.
// Depends on psrc_pkg and the paced_segment_relay_controller top level.
`timescale 1ns / 100ps

module paced_segment_relay_controller_test;
   import psrc_pkg::*;

   localparam logic [1:0] K_UNKNOWN = 2'd3;
   localparam logic [1:0] R_LIVE    = 2'd1;
   localparam logic [63:0] TIME_MAX = (64'd1 << TIME_BITS) - 1;
   localparam int SETTLE_CYCLES = 40;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [119:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [4:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   paced_segment_relay_controller DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mirror of the register file.
   logic [15:0] cfg_seg = 16'd6000;
   logic [15:0] cfg_delay = 16'd0;
   logic [15:0] cfg_grace = 16'd30;
   logic        cfg_replay = 1'b0;
   logic [31:0] cfg_in = '0;
   logic [31:0] cfg_out = '0;
   logic        cfg_listen = 1'b0;

   // Mirror of the relay state.
   logic [3:0]  st_mode = M_IDLE;
   logic [31:0] st_head = '0;
   logic        st_head_ok = 1'b0;
   logic [63:0] st_anchor_t = '0;
   logic [31:0] st_anchor_seq = '0;
   logic [63:0] st_retry = '0;
   logic [63:0] st_backoff = '0;
   logic [63:0] st_since_stream = '0, st_since_overdue = '0, st_since_backed = '0;
   logic        st_stream_ok = 1'b0, st_overdue_ok = 1'b0, st_backed_ok = 1'b0;
   logic [15:0] st_restarts = '0;

   req_type request_backlog[$];
   rsp_type expected_results[$];
   int errors = 0;

   function automatic logic [63:0] seg_len();
      return (cfg_seg > 16'd100) ? 64'(cfg_seg) : 64'd6000;
   endfunction

   function automatic logic [63:0] sat_time(logic [63:0] a, logic [63:0] b);
      logic [63:0] s;
      s = a + b;
      return (s > TIME_MAX) ? TIME_MAX : s;
   endfunction

   function automatic bit elapsed(logic [63:0] now, logic [63:0] since, logic [63:0] thr);
      return now >= since && now - since >= thr;
   endfunction

   // Start point behind the live edge, kept inside the storage window.
   function automatic logic [31:0] live_start(logic [31:0] newest, logic [31:0] oldest);
      logic [63:0] back, want;
      back = (64'(cfg_delay) * 64'd1000) / seg_len();
      want = (64'(newest) > back) ? 64'(newest) - back : 64'd0;
      if (want < 64'(oldest)) want = 64'(oldest);
      if (want > 64'(newest)) want = 64'(newest);
      return want[31:0];
   endfunction

   function automatic void enter_mode(logic [3:0] s, logic [63:0] now);
      st_mode = s;
      if (s == M_STREAM) begin
         st_since_stream = now;
         st_stream_ok = 1'b1;
      end
      if (s != M_AWAIT) st_backed_ok = 1'b0;
   endfunction

   // True while the head segment is still ahead of its 1x pacing slot.
   function automatic bit head_not_due(logic [63:0] now);
      logic [63:0] d;
      if (st_head >= st_anchor_seq) begin
         d = 64'(st_head - st_anchor_seq);
         if (now < st_anchor_t) return 1'b1;
         return (now - st_anchor_t) / seg_len() < d;
      end
      d = 64'(st_anchor_seq - st_head);
      if (d > st_anchor_t / seg_len()) return 1'b0;
      return now < st_anchor_t - d * seg_len();
   endfunction

   function automatic void relay_poll(input req_type r, output logic [2:0] act,
                                      output logic [31:0] fed, output logic [4:0] ev);
      logic [63:0] now, grace_ms;
      now = 64'(r.now_ms);
      grace_ms = 64'(cfg_grace) * 64'd1000;
      act = A_NONE;
      fed = '0;
      ev = E_NONE;
      if (!r.run_wanted) begin
         if (r.sender_alive) begin
            act = A_KILL; ev = E_OP_KILL; enter_mode(M_IDLE, now); st_head_ok = 1'b0;
            return;
         end
         if (st_mode != M_IDLE) begin
            enter_mode(M_IDLE, now); st_head_ok = 1'b0; ev = E_STOPPED;
         end
         return;
      end
      if (!r.feed_ok) begin
         if (r.sender_alive) begin
            act = A_KILL; ev = E_BLOCKED; enter_mode(M_BLOCK, now);
            return;
         end
         if (st_mode != M_BLOCK) begin
            enter_mode(M_BLOCK, now); ev = E_BLOCKED;
         end
         return;
      end
      if (st_mode == M_BLOCK) begin
         enter_mode(M_WAIT, now); ev = E_UNBLOCKED;
      end
      if (!r.sender_alive && (st_mode == M_STREAM || st_mode == M_STALL
                              || st_mode == M_AWAIT)) begin
         enter_mode(M_RECON, now); ev = E_LOST;
         return;
      end
      if (r.room_status == R_NONE) begin
         if (r.sender_alive) begin
            act = A_CLOSE; enter_mode(M_END, now); ev = E_ROOM_GONE;
            return;
         end
         if (st_mode != M_WAIT && st_mode != M_STOP) begin
            enter_mode(M_WAIT, now); ev = E_WAIT_START;
         end
         return;
      end
      // Sender is down: pick the head and spawn once the retry time is reached and content is ready.
      if (!r.sender_alive) begin
         if (st_mode == M_END) begin
            enter_mode(M_STOP, now); ev = E_ALL_SENT;
            return;
         end
         if (st_mode == M_STOP) return;
         if (!st_head_ok) begin
            st_head = cfg_replay ? ((cfg_in > r.oldest_seq) ? cfg_in : r.oldest_seq)
                                 : live_start(r.newest_seq, r.oldest_seq);
            st_head_ok = 1'b1;
         end else if (st_head < r.oldest_seq) begin
            st_head = r.oldest_seq;
         end
         if (now < st_retry) return;
         if (!r.init_present || !r.next_present) begin
            if (st_mode != M_WAIT) begin
               enter_mode(M_WAIT, now); ev = E_WAIT_DL;
            end
            return;
         end
         st_anchor_t = now;
         st_anchor_seq = st_head;
         act = A_SPAWN;
         ev = (st_mode == M_RECON) ? E_RESPAWN : E_SPAWN;
         enter_mode(M_STREAM, now);
         return;
      end
      if (cfg_out != 0 && st_head > cfg_out && st_mode != M_END) begin
         act = A_CLOSE; enter_mode(M_END, now); ev = E_OUT_POINT;
         return;
      end
      if (st_head > r.newest_seq && (r.room_status == R_ENDED || r.room_status == R_INTR)) begin
         if (st_mode != M_END) begin
            act = A_CLOSE; enter_mode(M_END, now);
            ev = (r.room_status == R_INTR) ? E_INTR : E_ENDED;
         end
         return;
      end
      if (st_mode == M_END) return;
      // Far end not taking content: wait for a listener, or time out on backpressure.
      if (!r.sink_accepting) begin
         if (cfg_listen && !r.sink_ever_accepted) begin
            if (st_mode != M_AWAIT) begin
               enter_mode(M_AWAIT, now); ev = E_AWAIT;
            end
            if (!cfg_replay) st_head = live_start(r.newest_seq, r.oldest_seq);
            return;
         end
         if (!st_backed_ok) begin
            st_since_backed = now; st_backed_ok = 1'b1;
         end
         if (elapsed(now, st_since_backed, grace_ms)) begin
            act = A_KILL; ev = E_BP_DROP; enter_mode(M_RECON, now);
            st_retry = sat_time(now, 64'd1000);
         end
         return;
      end
      if (st_mode == M_AWAIT) begin
         st_anchor_t = now; st_anchor_seq = st_head; st_overdue_ok = 1'b0;
         enter_mode(M_STREAM, now); ev = E_CONNECTED;
      end
      st_backed_ok = 1'b0;
      if (head_not_due(now)) begin
         st_overdue_ok = 1'b0;
         if (st_mode == M_STALL) begin
            enter_mode(M_STREAM, now); ev = E_FLOWING;
         end
         return;
      end
      // Segment is due but not downloaded: stall, then drop after the grace period.
      if (!r.next_present) begin
         if (!st_overdue_ok) begin
            st_since_overdue = now; st_overdue_ok = 1'b1;
         end
         if (elapsed(now, st_since_overdue, 64'd3000) && st_mode != M_STALL) begin
            enter_mode(M_STALL, now); ev = E_STALLED;
            return;
         end
         if (elapsed(now, st_since_overdue, grace_ms)) begin
            act = A_KILL; ev = E_STARVE; enter_mode(M_RECON, now);
            st_retry = sat_time(now, 64'd1000);
            st_overdue_ok = 1'b0;
         end
         return;
      end
      st_overdue_ok = 1'b0;
      if (st_mode == M_STALL) begin
         enter_mode(M_STREAM, now); ev = E_FLOWING;
      end
      act = A_FEED;
      fed = st_head;
      st_head = st_head + 32'd1;
   endfunction

   // Applies one accepted request to the mirror and returns the result it should give.
   function automatic rsp_type relay_outcome(req_type r);
      rsp_type o;
      logic [63:0] now;
      o = '0;
      now = 64'(r.now_ms);
      case (r.kind)
         K_POLL: relay_poll(r, o.action, o.fed_seq, o.event_code);
         K_EXIT: begin
            if (st_restarts != 16'hFFFF) st_restarts = st_restarts + 16'd1;
            if (st_stream_ok && now > st_since_stream && now - st_since_stream > 64'd120000)
               st_backoff = 0;
            if (st_backoff != 0) begin
               st_backoff = st_backoff * 2;
               if (st_backoff > 64'd15000) st_backoff = 64'd15000;
            end else begin
               st_backoff = 64'd1000;
            end
            st_retry = sat_time(now, st_backoff);
         end
         K_RECFG: begin
            st_mode = M_WAIT; st_head_ok = 1'b0; st_retry = 0;
            st_overdue_ok = 1'b0; st_backed_ok = 1'b0;
            st_since_stream = now; st_stream_ok = 1'b1;
         end
         default: ;
      endcase
      o.relay_state = st_mode;
      o.behind_valid = st_head_ok && (st_mode == M_STREAM || st_mode == M_STALL
                                      || st_mode == M_END);
      if (o.behind_valid && r.newest_seq >= st_head) o.segments_behind = r.newest_seq - st_head;
      o.restart_count = st_restarts;
      return o;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
      errors++;
   endtask

   // Request driver: bursts of requests with random gaps between them.
   req_type on_bus;
   int burst_left = 4;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) expected_results.push_back(relay_outcome(on_bus));
         if (req_tvalid && !req_tready) begin
            // Hold the request until it is taken.
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (request_backlog.size() > 0) begin
            on_bus = request_backlog.pop_front();
            req_tdata <= {7'd0, on_bus.sink_ever_accepted, on_bus.sink_accepting,
                          on_bus.next_present, on_bus.init_present, on_bus.newest_seq,
                          on_bus.oldest_seq, on_bus.room_status, on_bus.feed_ok,
                          on_bus.sender_alive, on_bus.run_wanted, on_bus.now_ms};
            req_tuser <= on_bus.kind;
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: stall style changes every so often; one long hold-off on request.
   logic long_hold_req = 1'b0;
   bit   long_hold_done = 1'b0;
   int   long_hold_left = 0;
   int   stall_style = 0;
   int   rx_cycle = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 97 == 0) stall_style = $urandom_range(0, 3);
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            long_hold_left = 400;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 2) != 0);
               2: rsp_tready <= (rx_cycle % 7) < 3;
               default: rsp_tready <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   // Result monitor: compare every taken result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.action = rsp_tdata[2:0];
         got.fed_seq = rsp_tdata[34:3];
         got.relay_state = rsp_tdata[38:35];
         got.event_code = rsp_tdata[43:39];
         got.segments_behind = rsp_tdata[75:44];
         got.behind_valid = rsp_tdata[76];
         got.restart_count = rsp_tdata[92:77];
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", 64'(got), 0);
         end else begin
            want = expected_results.pop_front();
            if (got.action != want.action) report_mismatch("action", got.action, want.action);
            if (got.fed_seq != want.fed_seq) report_mismatch("fed_seq", got.fed_seq, want.fed_seq);
            if (got.relay_state != want.relay_state)
               report_mismatch("relay_state", got.relay_state, want.relay_state);
            if (got.event_code != want.event_code)
               report_mismatch("event_code", got.event_code, want.event_code);
            if (got.segments_behind != want.segments_behind)
               report_mismatch("segments_behind", got.segments_behind, want.segments_behind);
            if (got.behind_valid != want.behind_valid)
               report_mismatch("behind_valid", got.behind_valid, want.behind_valid);
            if (got.restart_count != want.restart_count)
               report_mismatch("restart_count", got.restart_count, want.restart_count);
         end
      end
   end

   function automatic void push_req(logic [1:0] k, logic [63:0] now, bit run, bit alive,
                                    bit ok, logic [1:0] room, logic [31:0] oldest,
                                    logic [31:0] newest, bit init, bit nxt, bit acc,
                                    bit ever);
      req_type r;
      r.kind = k; r.now_ms = now[TIME_BITS-1:0];
      r.run_wanted = run; r.sender_alive = alive; r.feed_ok = ok; r.room_status = room;
      r.oldest_seq = oldest; r.newest_seq = newest;
      r.init_present = init; r.next_present = nxt;
      r.sink_accepting = acc; r.sink_ever_accepted = ever;
      request_backlog.push_back(r);
   endfunction

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (index)
         REG_SEGMENT_MS: cfg_seg = value[15:0];
         REG_DELAY:      cfg_delay = value[15:0];
         REG_GRACE:      cfg_grace = value[15:0];
         REG_REPLAY:     cfg_replay = value[0];
         REG_IN_POINT:   cfg_in = value;
         REG_OUT_POINT:  cfg_out = value;
         REG_LISTENER:   cfg_listen = value[0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [31:0] seg, logic [31:0] delay, logic [31:0] grace,
                            logic [31:0] replay, logic [31:0] in_pt, logic [31:0] out_pt,
                            logic [31:0] listen);
      csr_write(REG_SEGMENT_MS, seg);
      csr_write(REG_DELAY, delay);
      csr_write(REG_GRACE, grace);
      csr_write(REG_REPLAY, replay);
      csr_write(REG_IN_POINT, in_pt);
      csr_write(REG_OUT_POINT, out_pt);
      csr_write(REG_LISTENER, listen);
   endtask

   // Wait until every request is taken and answered, then let the block settle.
   task automatic drain();
      while (request_backlog.size() > 0 || req_tvalid || expected_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Plausible world: time moves forward, the live edge advances, the sender comes and goes.
   logic [63:0] w_now = 64'd1000;
   logic [31:0] w_newest = 32'd500, w_oldest = 32'd400;
   bit          w_alive = 1'b0;

   task automatic random_requests(int count);
      int pick;
      logic [1:0] k, room;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            push_req($urandom_range(0, 3), {$urandom, $urandom}, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
         end else begin
            w_now += $urandom_range(0, 2500);
            if ($urandom_range(0, 99) < 3) w_now += $urandom_range(0, 200000);
            if (w_now > TIME_MAX) w_now = 64'd0;
            if ($urandom_range(0, 2) == 0) w_newest += 32'd1;
            if ($urandom_range(0, 19) == 0) w_oldest = w_newest - $urandom_range(0, 50);
            if ($urandom_range(0, 99) < 12) w_alive = !w_alive;
            pick = $urandom_range(0, 99);
            k = (pick < 88) ? K_POLL : (pick < 94) ? K_EXIT : (pick < 98) ? K_RECFG
                                                                          : K_UNKNOWN;
            pick = $urandom_range(0, 99);
            room = (pick < 88) ? R_LIVE : (pick < 92) ? R_NONE : (pick < 96) ? R_ENDED
                                                                            : R_INTR;
            push_req(k, w_now, $urandom_range(0, 99) < 95, w_alive,
                     $urandom_range(0, 99) < 95, room, w_oldest, w_newest,
                     $urandom_range(0, 9) != 0, $urandom_range(0, 9) < 8,
                     $urandom_range(0, 9) < 9, $urandom_range(0, 9) != 0);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the reset settings.
      push_req(K_UNKNOWN, 0, 1, 1, 1, R_LIVE, 0, 10, 1, 1, 1, 1);
      push_req(K_RECFG, 10, 1, 1, 1, R_LIVE, 0, 10, 1, 1, 1, 1);
      for (int i = 0; i < 5; i++) push_req(K_EXIT, 100 + i * 100, 1, 0, 1, R_LIVE,
                                           0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 1000, 0, 1, 1, R_LIVE, 0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 1100, 1, 1, 0, R_LIVE, 0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 1200, 1, 0, 0, R_LIVE, 0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 1300, 0, 0, 1, R_LIVE, 0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 1400, 1, 0, 0, R_LIVE, 0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 1500, 1, 0, 1, R_NONE, 0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 1600, 1, 1, 1, R_NONE, 0, 10, 1, 1, 1, 1);
      push_req(K_POLL, 100000, 1, 0, 1, R_LIVE, 0, 32'hFFFF_FFFF, 1, 1, 1, 1);
      push_req(K_POLL, 100000, 1, 1, 1, R_LIVE, 0, 32'hFFFF_FFFF, 1, 1, 1, 1);
      push_req(K_POLL, 99000, 1, 1, 1, R_LIVE, 0, 32'hFFFF_FFFF, 1, 0, 1, 1);
      push_req(K_POLL, 103500, 1, 1, 1, R_LIVE, 0, 32'hFFFF_FFFF, 1, 0, 1, 1);
      push_req(K_POLL, 140000, 1, 1, 1, R_LIVE, 0, 32'hFFFF_FFFF, 1, 0, 1, 1);
      push_req(K_EXIT, TIME_MAX, 1, 0, 1, R_LIVE, 0, 5, 1, 1, 1, 1);
      push_req(K_RECFG, 200000, 1, 0, 1, R_LIVE, 0, 5, 1, 1, 1, 1);
      push_req(K_POLL, 201000, 1, 0, 1, R_LIVE, 10, 20, 1, 1, 1, 1);
      push_req(K_POLL, 202000, 1, 1, 1, R_INTR, 10, 5, 1, 1, 0, 1);
      push_req(K_POLL, 203000, 1, 0, 1, R_ENDED, 10, 5, 1, 1, 1, 1);
      drain();

      // Extremes of every register.
      configure(0, 16'hFFFF, 16'hFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      random_requests(80);
      drain();
      configure(16'hFFFF, 0, 0, 0, 0, 0, 0);
      random_requests(60);
      drain();

      // Short segments and grace so pacing, stalls and drops happen often.
      configure(200, 2, 5, 0, 0, 0, 0);
      random_requests(30);
      long_hold_req <= 1'b1;
      random_requests(70);
      drain();

      for (int p = 0; p < 3; p++) begin
         configure($urandom_range(0, 3000), $urandom_range(0, 20), $urandom_range(0, 12),
                   $urandom_range(0, 1), w_oldest + $urandom_range(0, 20),
                   ($urandom_range(0, 1) == 0) ? 0 : w_newest + $urandom_range(0, 60),
                   $urandom_range(0, 1));
         random_requests(85);
         drain();
      end

      if (errors == 0) begin
         $display("paced_segment_relay_controller_test passed");
      end else begin
         $display("paced_segment_relay_controller_test failed");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("paced_segment_relay_controller_test failed");
      $finish;
   end

endmodule
